### hdl/msk_pkg.sv
package msk_pkg;

    // Counter width for the segment and unit totals
    localparam int COUNTER_BITS = 32;
    // Width of the totals as shown on the result channel
    localparam int OUT_CNT_W    = 32;

    localparam int SYM_W     = 8;
    localparam int DUR_W     = 4;
    localparam int CFG_IDX_W = 3;

    // One input produces at most three segments: two for the held symbol,
    // one for a final symbol that closes the phrase.
    localparam int MAX_SEGS  = 3;
    localparam int SEG_IDX_W = $clog2(MAX_SEGS);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Symbol codes
    localparam logic [SYM_W-1:0] SYM_DOT   = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_DASH  = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] SYM_NONE  = 8'h00;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIT          = 3'd0,
        CFG_DASH         = 3'd1,
        CFG_ELEMENT_GAP  = 3'd2,
        CFG_LETTER_GAP   = 3'd3,
        CFG_WORD_GAP     = 3'd4
    } cfg_idx_t;

    // Register reset values
    localparam logic [DUR_W-1:0] DIT_RST         = 4'd1;
    localparam logic [DUR_W-1:0] DASH_RST        = 4'd3;
    localparam logic [DUR_W-1:0] ELEMENT_GAP_RST = 4'd1;
    localparam logic [DUR_W-1:0] LETTER_GAP_RST  = 4'd3;
    localparam logic [DUR_W-1:0] WORD_GAP_RST    = 4'd7;

    // Segment list built for one input transaction
    typedef struct packed {
        logic [MAX_SEGS-1:0]            level;
        logic [MAX_SEGS-1:0][DUR_W-1:0] dur;
        logic [SEG_IDX_W-1:0]           last_idx;
    } msk_plan_t;

    // Saturating add of two counter-width values
    function automatic logic [COUNTER_BITS-1:0] sat_add(
        input logic [COUNTER_BITS-1:0] a,
        input logic [COUNTER_BITS-1:0] b
    );
        logic [COUNTER_BITS:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[COUNTER_BITS] ? {COUNTER_BITS{1'b1}} : sum[COUNTER_BITS-1:0];
        end
    endfunction

endpackage

### hdl/morse_symbol_keyer.sv
// Morse symbol keyer.
// Input channel (s_*): one symbol byte per transaction in s_tdata, with
// s_tlast marking the last symbol of a phrase. Dot, dash, slash and space
// act; other bytes produce nothing but still serve as lookahead.
// Result channel (m_*): one LED segment per transaction: level, duration in
// time units, and saturating running totals of segments and units. m_tlast
// marks the last segment produced for one input transaction.
// Configuration: cfg_wr_en/cfg_index/cfg_data write the five timing
// registers (dit, dash, element gap, letter gap, word gap), idle only.
// Timing: an accepted input's segments pass through the plan queue and the
// registered output stage before they appear on m_*. The back end emits one
// segment per cycle while m_tready is high; an input causes 0 to 3 segments,
// and one that causes none is not queued. The output stage sets the rate.
// A two-entry queue between the symbol front end and the segment emitter
// lets s_tready stay high while m_tready is low, until the queue fills.
// Reset (aresetn low, synchronous) restores the default timings, clears
// the lookahead symbol and both totals, and empties the queue.
module morse_symbol_keyer
    import msk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    // symbol input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] symbol
    input  logic                 s_tlast,   // string_end
    // segment output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // [0] led_on, [4:1] duration_units,
                                            // [36:5] segment_count,
                                            // [68:37] total_units, [71:69] zero
    output logic                 m_tlast    // run_last
);

    logic                 q_full;
    logic                 q_not_empty;
    logic                 q_pop;
    logic                 plan_push;
    msk_plan_t            plan;
    msk_plan_t            q_head;
    logic                 seg_level;
    logic [DUR_W-1:0]     seg_dur;
    logic [OUT_CNT_W-1:0] seg_cnt;
    logic [OUT_CNT_W-1:0] seg_units;

    msk_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_symbol (s_tdata[SYM_W-1:0]),
        .in_end    (s_tlast),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .plan_push (plan_push),
        .plan      (plan)
    );

    msk_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (plan_push),
        .push_data (plan),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    msk_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_level   (seg_level),
        .out_dur     (seg_dur),
        .out_seg_cnt (seg_cnt),
        .out_units   (seg_units),
        .out_last    (m_tlast)
    );

    // Pack the segment fields, lowest first
    assign m_tdata = {3'b000, seg_units, seg_cnt, seg_dur, seg_level};

endmodule

### hdl/msk_front.sv
module msk_front
    import msk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    // symbol input
    input  logic                 in_valid,
    input  logic [SYM_W-1:0]     in_symbol,
    input  logic                 in_end,
    input  logic                 q_full,
    output logic                 in_ready,
    // plan output to queue
    output logic                 plan_push,
    output msk_plan_t            plan
);

    logic [DUR_W-1:0] dit_reg, dash_reg, egap_reg, lgap_reg, wgap_reg;
    logic [SYM_W-1:0] held_reg, held_next;
    logic             held_vld_reg, held_vld_next;
    logic [SYM_W-1:0] prev_reg, prev_next;

    logic             accept;
    logic [1:0]       n_held;
    logic             held_on, held_gap;
    logic [DUR_W-1:0] held_on_dur, held_gap_dur;
    logic             new_on;
    logic [DUR_W-1:0] new_on_dur;
    logic [1:0]       n_total;

    assign in_ready = ~q_full;
    assign accept   = in_valid & in_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dit_reg  <= DIT_RST;
            dash_reg <= DASH_RST;
            egap_reg <= ELEMENT_GAP_RST;
            lgap_reg <= LETTER_GAP_RST;
            wgap_reg <= WORD_GAP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DIT:         dit_reg  <= cfg_data;
                CFG_DASH:        dash_reg <= cfg_data;
                CFG_ELEMENT_GAP: egap_reg <= cfg_data;
                CFG_LETTER_GAP:  lgap_reg <= cfg_data;
                CFG_WORD_GAP:    wgap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the held symbol, using the incoming symbol as lookahead
    always_comb begin
        held_on      = 1'b0;
        held_gap     = 1'b0;
        held_on_dur  = dit_reg;
        held_gap_dur = egap_reg;
        if (held_vld_reg) begin
            if (held_reg == SYM_DOT || held_reg == SYM_DASH) begin
                held_on     = 1'b1;
                held_on_dur = (held_reg == SYM_DOT) ? dit_reg : dash_reg;
                held_gap    = (in_symbol != SYM_SPACE);
            end else if (held_reg == SYM_SLASH) begin
                held_gap     = 1'b1;
                held_gap_dur = wgap_reg;
            end else if (held_reg == SYM_SPACE) begin
                held_gap     = (in_symbol != SYM_SLASH) && (prev_reg != SYM_SLASH);
                held_gap_dur = lgap_reg;
            end
        end
        n_held = {1'b0, held_on} + {1'b0, held_gap};
    end

    // A symbol that ends the phrase: only dot and dash emit, with no gap
    always_comb begin
        new_on     = in_end && (in_symbol == SYM_DOT || in_symbol == SYM_DASH);
        new_on_dur = (in_symbol == SYM_DOT) ? dit_reg : dash_reg;
        n_total    = n_held + {1'b0, new_on};
    end

    // Pack segments in order into the plan
    always_comb begin
        plan.level = '0;
        plan.dur   = '0;
        if (held_on) begin
            plan.level[0] = 1'b1;
            plan.dur[0]   = held_on_dur;
            if (held_gap) begin
                plan.dur[1] = held_gap_dur;
            end
        end else if (held_gap) begin
            plan.dur[0] = held_gap_dur;
        end
        if (new_on) begin
            plan.level[n_held] = 1'b1;
            plan.dur[n_held]   = new_on_dur;
        end
        plan.last_idx = SEG_IDX_W'(n_total - 2'd1);
        plan_push     = accept && (n_total != 2'd0);
    end

    // Lookahead state
    always_comb begin
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        prev_next     = prev_reg;
        if (accept) begin
            if (held_vld_reg) begin
                prev_next = held_reg;
            end
            if (in_end) begin
                held_next     = SYM_NONE;
                held_vld_next = 1'b0;
                prev_next     = SYM_NONE;
            end else begin
                held_next     = in_symbol;
                held_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= SYM_NONE;
            held_vld_reg <= 1'b0;
            prev_reg     <= SYM_NONE;
        end else begin
            held_reg     <= held_next;
            held_vld_reg <= held_vld_next;
            prev_reg     <= prev_next;
        end
    end

endmodule

### hdl/msk_fifo.sv
module msk_fifo
    import msk_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  msk_plan_t push_data,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output msk_plan_t head
);

    msk_plan_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/msk_back.sv
module msk_back
    import msk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  msk_plan_t            q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_level,
    output logic [DUR_W-1:0]     out_dur,
    output logic [OUT_CNT_W-1:0] out_seg_cnt,
    output logic [OUT_CNT_W-1:0] out_units,
    output logic                 out_last
);

    logic [SEG_IDX_W-1:0]    idx_reg, idx_next;
    logic [COUNTER_BITS-1:0] seg_cnt_reg, seg_cnt_next;
    logic [COUNTER_BITS-1:0] units_reg, units_next;
    logic                    vld_reg, vld_next;
    logic                    level_reg;
    logic [DUR_W-1:0]        dur_reg;
    logic                    last_reg;
    logic                    load;
    logic                    seg_last;

    // Step through the head entry one segment per cycle while the output is free or taken
    always_comb begin
        load         = q_not_empty && (!vld_reg || out_ready);
        seg_last     = (idx_reg == q_head.last_idx);
        q_pop        = load && seg_last;
        idx_next     = idx_reg;
        seg_cnt_next = seg_cnt_reg;
        units_next   = units_reg;
        vld_next     = vld_reg;
        if (load) begin
            idx_next     = seg_last ? '0 : idx_reg + 1'b1;
            seg_cnt_next = sat_add(seg_cnt_reg, COUNTER_BITS'(1));
            units_next   = sat_add(units_reg, COUNTER_BITS'(q_head.dur[idx_reg]));
            vld_next     = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            seg_cnt_reg <= '0;
            units_reg   <= '0;
            vld_reg     <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            seg_cnt_reg <= seg_cnt_next;
            units_reg   <= units_next;
            vld_reg     <= vld_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            level_reg <= q_head.level[idx_reg];
            dur_reg   <= q_head.dur[idx_reg];
            last_reg  <= seg_last;
        end
    end

    assign out_valid   = vld_reg;
    assign out_level   = level_reg;
    assign out_dur     = dur_reg;
    assign out_seg_cnt = OUT_CNT_W'(seg_cnt_reg);
    assign out_units   = OUT_CNT_W'(units_reg);
    assign out_last    = last_reg;

endmodule

### test/tb_morse_symbol_keyer.sv
module tb_morse_symbol_keyer
    import msk_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PHASES = 6;
    localparam int RANDOM_ACTING = 360;
    localparam logic LED_ON  = 1'b1;
    localparam logic LED_OFF = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_WORD_GAP + 1);

    // One LED segment as seen on the result channel
    typedef struct {
        logic                    led;
        logic [DUR_W-1:0]        dur;
        logic [OUT_CNT_W-1:0]    segs;
        logic [OUT_CNT_W-1:0]    units;
        logic                    last;
    } segment_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [71:0]          m_tdata;
    logic                 m_tlast;

    morse_symbol_keyer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Keyer model state
    logic [DUR_W-1:0]        timing [5];
    logic [SYM_W-1:0]        held_sym;
    logic                    held_valid;
    logic [SYM_W-1:0]        prev_sym;
    logic [COUNTER_BITS-1:0] seg_total;
    logic [COUNTER_BITS-1:0] unit_total;

    segment_t pending_segments[$];
    segment_t expected_segments[$];

    int  errors;
    int  symbols_sent;
    int  segments_seen;
    int  timing_sets;
    int  cycle_count;
    bit  src_no_gaps;
    bit  sink_no_stalls;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d segments outstanding",
                     cycle_count, expected_segments.size());
            $display("tb_morse_symbol_keyer: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic logic [COUNTER_BITS-1:0] sat_inc(
        input logic [COUNTER_BITS-1:0] acc,
        input logic [COUNTER_BITS-1:0] step
    );
        logic [COUNTER_BITS:0] wide;
        wide = {1'b0, acc} + {1'b0, step};
        return wide[COUNTER_BITS] ? '1 : wide[COUNTER_BITS-1:0];
    endfunction

    function automatic void add_segment(input logic led, input logic [DUR_W-1:0] dur);
        segment_t seg;
        seg_total  = sat_inc(seg_total, COUNTER_BITS'(1));
        unit_total = sat_inc(unit_total, COUNTER_BITS'(dur));
        seg.led   = led;
        seg.dur   = dur;
        seg.segs  = seg_total[OUT_CNT_W-1:0];
        seg.units = unit_total[OUT_CNT_W-1:0];
        seg.last  = 1'b0;
        pending_segments.push_back(seg);
    endfunction

    // Segments for one symbol, given its successor and predecessor
    function automatic void key_one(input logic [SYM_W-1:0] sym, input logic [SYM_W-1:0] nxt,
                                    input logic nxt_end, input logic [SYM_W-1:0] prev);
        case (sym)
            SYM_DOT, SYM_DASH: begin
                add_segment(LED_ON, (sym == SYM_DOT) ? timing[CFG_DIT] : timing[CFG_DASH]);
                if (!(nxt_end || nxt == SYM_SPACE))
                    add_segment(LED_OFF, timing[CFG_ELEMENT_GAP]);
            end
            SYM_SLASH: begin
                if (!nxt_end)
                    add_segment(LED_OFF, timing[CFG_WORD_GAP]);
            end
            SYM_SPACE: begin
                if (!(nxt_end || nxt == SYM_SLASH || prev == SYM_SLASH))
                    add_segment(LED_OFF, timing[CFG_LETTER_GAP]);
            end
            default: ;
        endcase
    endfunction

    // Expected segments for one accepted symbol transaction
    function automatic void key_symbol(input logic [SYM_W-1:0] sym, input logic phrase_end);
        segment_t seg;
        if (held_valid) begin
            key_one(held_sym, sym, 1'b0, prev_sym);
            prev_sym = held_sym;
        end
        if (phrase_end) begin
            key_one(sym, SYM_NONE, 1'b1, prev_sym);
            held_sym   = SYM_NONE;
            held_valid = 1'b0;
            prev_sym   = SYM_NONE;
        end else begin
            held_sym   = sym;
            held_valid = 1'b1;
        end
        for (int i = 0; i < pending_segments.size(); i++) begin
            seg = pending_segments[i];
            seg.last = (i == pending_segments.size() - 1);
            expected_segments.push_back(seg);
        end
        pending_segments.delete();
    endfunction

    function automatic void reset_keyer_model();
        timing[CFG_DIT]         = DIT_RST;
        timing[CFG_DASH]        = DASH_RST;
        timing[CFG_ELEMENT_GAP] = ELEMENT_GAP_RST;
        timing[CFG_LETTER_GAP]  = LETTER_GAP_RST;
        timing[CFG_WORD_GAP]    = WORD_GAP_RST;
        held_sym   = SYM_NONE;
        held_valid = 1'b0;
        prev_sym   = SYM_NONE;
        seg_total  = '0;
        unit_total = '0;
    endfunction

    // Send one symbol transaction; valid stays up when the next follows at once
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic phrase_end);
        int gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= phrase_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        key_symbol(sym, phrase_end);
        symbols_sent++;
    endtask

    // Wait until every expected segment is out, plus the cost of silent symbols
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_segments.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        if (idx <= CFG_WORD_GAP)
            timing[idx] = val;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_timings(input logic [DUR_W-1:0] dit, input logic [DUR_W-1:0] dash,
                               input logic [DUR_W-1:0] egap, input logic [DUR_W-1:0] lgap,
                               input logic [DUR_W-1:0] wgap);
        wait_idle();
        write_reg(CFG_DIT, dit);
        write_reg(CFG_DASH, dash);
        write_reg(CFG_ELEMENT_GAP, egap);
        write_reg(CFG_LETTER_GAP, lgap);
        write_reg(CFG_WORD_GAP, wgap);
        timing_sets++;
    endtask

    // Result checker with random back-pressure
    initial begin : segment_sink
        segment_t    want;
        logic [71:0] got;
        int          hold;
        m_tready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata;
                segments_seen++;
                if (expected_segments.size() == 0) begin
                    report_mismatch("segment with none expected, count", got[36:5], 0);
                end else begin
                    want = expected_segments.pop_front();
                    if (got[0] !== want.led)
                        report_mismatch("led_on", 32'(got[0]), 32'(want.led));
                    if (got[4:1] !== want.dur)
                        report_mismatch("duration_units", 32'(got[4:1]), 32'(want.dur));
                    if (got[36:5] !== want.segs)
                        report_mismatch("segment_count", got[36:5], want.segs);
                    if (got[68:37] !== want.units)
                        report_mismatch("total_units", got[68:37], want.units);
                    if (got[71:69] !== 3'b000)
                        report_mismatch("tdata padding", 32'(got[71:69]), 0);
                    if (m_tlast !== want.last)
                        report_mismatch("run_last", 32'(m_tlast), 32'(want.last));
                end
                hold = sink_no_stalls ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Space at phrase start, spaces next to slashes, slash that closes a phrase
    task automatic test_phrase_edges();
        send_symbol(SYM_SPACE, 1'b0);
        send_symbol(SYM_DOT, 1'b0);
        send_symbol(SYM_DASH, 1'b0);
        send_symbol(SYM_SPACE, 1'b0);
        send_symbol(SYM_SLASH, 1'b0);
        send_symbol(SYM_SPACE, 1'b0);
        send_symbol(SYM_DOT, 1'b0);
        send_symbol(SYM_SLASH, 1'b1);
    endtask

    // Ignored bytes (zero included) as symbols, successors and predecessors
    task automatic test_ignored_bytes();
        send_symbol(8'h00, 1'b0);
        send_symbol(SYM_DOT, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(SYM_SPACE, 1'b0);
        send_symbol(8'h41, 1'b1);
        send_symbol(SYM_DASH, 1'b1);
        send_symbol(SYM_SPACE, 1'b1);
        send_symbol(8'h00, 1'b1);
    endtask

    // All registers at zero, then all at their maximum
    task automatic test_timing_extremes();
        set_timings(4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        send_symbol(SYM_DOT, 1'b0);
        send_symbol(SYM_DASH, 1'b0);
        send_symbol(SYM_SPACE, 1'b0);
        send_symbol(SYM_SLASH, 1'b0);
        send_symbol(SYM_DOT, 1'b1);
        set_timings(4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
        send_symbol(SYM_DASH, 1'b0);
        send_symbol(SYM_SLASH, 1'b0);
        send_symbol(SYM_DOT, 1'b0);
        send_symbol(SYM_SPACE, 1'b0);
        send_symbol(SYM_DASH, 1'b1);
    endtask

    // Writes past the last register must leave the timings alone
    task automatic test_unused_indexes();
        set_timings(4'd2, 4'd5, 4'd1, 4'd4, 4'd9);
        for (int i = CFG_FIRST_UNUSED; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), DUR_W'($urandom_range(0, 15)));
        send_symbol(SYM_DOT, 1'b0);
        send_symbol(SYM_SPACE, 1'b0);
        send_symbol(SYM_SLASH, 1'b0);
        send_symbol(SYM_DASH, 1'b1);
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return SYM_DOT;
        if (r < 55) return SYM_DASH;
        if (r < 67) return SYM_SLASH;
        if (r < 82) return SYM_SPACE;
        return SYM_W'($urandom_range(0, 255));
    endfunction

    // Random phrases under several timing settings and idling patterns
    task automatic test_random_phrases();
        logic [SYM_W-1:0] sym;
        int               acting;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)
                set_timings(DIT_RST, DASH_RST, ELEMENT_GAP_RST, LETTER_GAP_RST, WORD_GAP_RST);
            else
                set_timings(DUR_W'($urandom_range(0, 15)), DUR_W'($urandom_range(0, 15)),
                            DUR_W'($urandom_range(0, 15)), DUR_W'($urandom_range(0, 15)),
                            DUR_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 1))
                write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 2 ** CFG_IDX_W - 1)),
                          DUR_W'($urandom_range(0, 15)));
            src_no_gaps    = (phase % 3 == 1);
            sink_no_stalls = (phase % 3 == 2) || (phase == 4);
            acting = 0;
            while (acting < RANDOM_ACTING / RANDOM_PHASES) begin
                sym = pick_symbol();
                send_symbol(sym, $urandom_range(0, 6) == 0);
                if (sym == SYM_DOT || sym == SYM_DASH || sym == SYM_SLASH || sym == SYM_SPACE)
                    acting++;
            end
        end
        src_no_gaps    = 1'b0;
        sink_no_stalls = 1'b0;
    endtask

    initial begin
        errors         = 0;
        symbols_sent   = 0;
        segments_seen  = 0;
        timing_sets    = 0;
        src_no_gaps    = 1'b0;
        sink_no_stalls = 1'b0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_DIT;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        reset_keyer_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_phrase_edges();
        test_ignored_bytes();
        test_timing_extremes();
        test_unused_indexes();
        test_random_phrases();

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("%0d symbols keyed into %0d LED segments over %0d timing settings",
                 symbols_sent, segments_seen, timing_sets);
        $display("phrase edges, ignored bytes, zero and max timings, unused register writes");
        if (errors == 0) begin
            $display("tb_morse_symbol_keyer: done, clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_morse_symbol_keyer: done, errors");
        end
        $finish;
    end

endmodule

### files.f
hdl/msk_pkg.sv
hdl/msk_front.sv
hdl/msk_fifo.sv
hdl/msk_back.sv
hdl/morse_symbol_keyer.sv
test/tb_morse_symbol_keyer.sv
